@@ hdl/nested_block_end_finder_unit_defines.svh @@
// Assertion macros used by the block end finder top level.
`ifndef NESTED_BLOCK_END_FINDER_UNIT_DEFINES_SVH
`define NESTED_BLOCK_END_FINDER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define NBEF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define NBEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nbef_pkg.sv @@
// Types, constants and marker codes for the block end finder.
package nbef_pkg;

  // Nesting and offset sizing
  localparam int MAX_DEPTH   = 255;
  localparam int OFFSET_BITS = 16;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int OFFSET_W    = 16;
  localparam int SKIP_W      = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Marker codes
  localparam logic [15:0] HI_SKIP        = 16'h0411;
  localparam logic [15:0] HI_LOOP_OPEN0  = 16'h0820;
  localparam logic [15:0] HI_LOOP_OPEN1  = 16'h0821;
  localparam logic [15:0] HI_LOOP_OPEN2  = 16'h0822;
  localparam logic [15:0] HI_LOOP_CLOSE0 = 16'h0830;
  localparam logic [15:0] HI_LOOP_CLOSE1 = 16'h0831;
  localparam logic [15:0] HI_LOOP_CLOSE2 = 16'h0832;
  localparam logic [31:0] WORD_IF_OPEN   = 32'h3000_0000;
  localparam logic [31:0] WORD_IF_CLOSE  = 32'h3000_8000;

  // Search kinds and result codes
  localparam logic MODE_LOOP        = 1'b0;
  localparam logic MODE_IF          = 1'b1;
  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    logic [31:0] word;
    logic        begin_search;
    logic        kind;
    logic        last_word;
  } nbef_in_t;

  typedef struct packed {
    logic                status;
    logic [OFFSET_W-1:0] offset;
    logic [31:0]         prev_word;
  } nbef_out_t;

  // Classified item held in the queue
  typedef struct packed {
    logic [31:0] word;
    logic        begin_search;
    logic        kind;
    logic        last_word;
    logic        skip_mark;
    logic        loop_open;
    logic        loop_close;
    logic        if_open;
    logic        if_close;
  } nbef_cls_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } nbef_qstat_t;

endpackage

@@ hdl/nbef_front.sv @@
// Front end: accepts items and classifies their marker codes.
module nbef_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nbef_pkg::nbef_in_t   in_data,
  input  nbef_pkg::nbef_qstat_t q_stat,
  output logic                 push,
  output nbef_pkg::nbef_cls_t  push_data
);
  import nbef_pkg::*;

  logic [15:0] hi;

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Decode all marker classes; the back end picks by mode
  assign hi = in_data.word[31:16];
  always_comb begin
    push_data.word         = in_data.word;
    push_data.begin_search = in_data.begin_search;
    push_data.kind         = in_data.kind;
    push_data.last_word    = in_data.last_word;
    push_data.skip_mark    = (hi == HI_SKIP);
    push_data.loop_open    = (hi == HI_LOOP_OPEN0) || (hi == HI_LOOP_OPEN1) ||
                             (hi == HI_LOOP_OPEN2);
    push_data.loop_close   = (hi == HI_LOOP_CLOSE0) || (hi == HI_LOOP_CLOSE1) ||
                             (hi == HI_LOOP_CLOSE2);
    push_data.if_open      = (in_data.word == WORD_IF_OPEN);
    push_data.if_close     = (in_data.word == WORD_IF_CLOSE);
  end

endmodule

@@ hdl/nbef_queue.sv @@
// Short queue of classified items between front and back.
module nbef_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  nbef_pkg::nbef_cls_t   push_data,
  input  logic                  pop,
  output nbef_pkg::nbef_cls_t   head,
  output nbef_pkg::nbef_qstat_t q_stat
);
  import nbef_pkg::*;

  nbef_cls_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;

  // Status and head entry
  assign q_stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = mem[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/nbef_back.sv @@
// Back end: tracks nesting and skips, and registers the result item.
module nbef_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nbef_pkg::nbef_cls_t   head,
  input  nbef_pkg::nbef_qstat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nbef_pkg::nbef_out_t   out_data
);
  import nbef_pkg::*;

  logic                   searching_r, searching_nxt;
  logic                   mode_r, mode_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [SKIP_W-1:0]      skip_r, skip_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]            prev_r, prev_nxt;
  logic                   out_valid_r, out_valid_nxt;
  nbef_out_t              out_data_r, out_data_nxt;

  logic                   mode;
  logic [DEPTH_W-1:0]     depth_cur;
  logic [SKIP_W-1:0]      skip_cur;
  logic [OFFSET_BITS-1:0] pos_cur;
  logic [31:0]            prev_cur;
  logic [31:0]            pos_ext;
  logic                   is_open, is_close, matched;

  // Take the head when the output slot is free or drains this cycle
  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  // A new search starts from cleared state
  assign mode      = head.begin_search ? head.kind : mode_r;
  assign depth_cur = head.begin_search ? '0 : depth_r;
  assign skip_cur  = head.begin_search ? '0 : skip_r;
  assign pos_cur   = head.begin_search ? '0 : pos_r;
  assign prev_cur  = head.begin_search ? '0 : prev_r;
  assign pos_ext   = 32'(pos_cur);

  // Step the search by one item
  always_comb begin
    searching_nxt = searching_r;
    mode_nxt      = mode_r;
    depth_nxt     = depth_r;
    skip_nxt      = skip_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    is_open       = 1'b0;
    is_close      = 1'b0;
    matched       = 1'b0;
    if (pop) begin
      if (head.begin_search) begin
        mode_nxt = head.kind;
      end
      if (head.begin_search || searching_r) begin
        searching_nxt = 1'b1;
        depth_nxt     = depth_cur;
        skip_nxt      = skip_cur;
        pos_nxt       = pos_cur;
        prev_nxt      = prev_cur;
        // Skipped words are not decoded
        if (skip_cur != '0) begin
          skip_nxt = skip_cur - 1'b1;
        end else if (head.skip_mark) begin
          skip_nxt = head.word[SKIP_W-1:0];
        end else if (mode == MODE_LOOP) begin
          is_open  = head.loop_open;
          is_close = head.loop_close;
        end else begin
          is_open  = head.if_open;
          is_close = head.if_close;
        end
        // Update depth; a close at depth zero ends the search
        if (is_open) begin
          if (depth_cur < DEPTH_W'(MAX_DEPTH)) begin
            depth_nxt = depth_cur + 1'b1;
          end
        end else if (is_close) begin
          if (depth_cur != '0) begin
            depth_nxt = depth_cur - 1'b1;
          end else begin
            matched                = 1'b1;
            searching_nxt          = 1'b0;
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = STATUS_FOUND;
            out_data_nxt.offset    = pos_ext[OFFSET_W-1:0];
            out_data_nxt.prev_word = prev_cur;
          end
        end
        if (!matched) begin
          if (head.last_word) begin
            searching_nxt          = 1'b0;
            out_valid_nxt          = 1'b1;
            out_data_nxt.status    = STATUS_NOT_FOUND;
            out_data_nxt.offset    = '0;
            out_data_nxt.prev_word = '0;
          end else begin
            prev_nxt = head.word;
            pos_nxt  = pos_cur + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r <= 1'b0;
      mode_r      <= MODE_LOOP;
      depth_r     <= '0;
      skip_r      <= '0;
      pos_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      searching_r <= searching_nxt;
      mode_r      <= mode_nxt;
      depth_r     <= depth_nxt;
      skip_r      <= skip_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/nested_block_end_finder_unit.sv @@
// Top level of the block end finder: front, queue and back end.
//
//  Channel  Ports                          Moves
//  input    in_valid / in_ready / in_data  one object word item with search flags
//  output   out_valid / out_ready / out_data  one result item (found or not found)
//
// One item per cycle sustained while no result is stalled; the back end steps one queued item per cycle.
// A result is registered in the back end once the item that causes it has passed through the queue.
// A four-entry queue parts front and back, so in_ready stays high while it has room.
// A stalled result holds the back end; the queue absorbs the input meanwhile.
// Synchronous active-low reset clears the queue, search state and output valid.
`include "nested_block_end_finder_unit_defines.svh"

module nested_block_end_finder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nbef_pkg::nbef_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nbef_pkg::nbef_out_t out_data
);
  import nbef_pkg::*;

  nbef_qstat_t q_stat;
  nbef_cls_t   push_data;
  nbef_cls_t   head;
  logic        push;
  logic        pop;

  nbef_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  nbef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  nbef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Queue never reports full and empty together
  `NBEF_ASSERT_SAME(a_q_consistent, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  // Back end only takes items that exist
  `NBEF_ASSERT_SAME(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")
  // A stalled result freezes the back end
  `NBEF_ASSERT_SAME(a_stall_hold, out_valid && !out_ready, !pop, "pop while result stalled")
  // A queue that was full and saw no pop stays full
  `NBEF_ASSERT_NEXT(a_full_hold, q_stat.full && !pop, q_stat.full, "full queue drained without pop")

endmodule
